// ===== rtl/rcb_pkg.sv =====
// Shared types, constants and helpers for the red channel 5x5 blur.
package rcb_pkg;

  localparam int MaxLineWidth = 2048;
  localparam int MaxRows      = 4096;
  localparam int Taps         = 5;
  localparam int Slots        = Taps - 1;
  localparam int Classes      = 6;

  localparam int PixW       = 32;
  localparam int RedW       = 8;
  localparam int LineWidthW = 12;
  localparam int WeightW    = 16;
  localparam int FracW      = 8;
  localparam int ProdW      = RedW + WeightW;
  localparam int ColW       = $clog2(MaxLineWidth);
  localparam int RowW       = $clog2(MaxRows);
  localparam int SlotW      = $clog2(Slots);
  localparam int ClassW     = $clog2(Classes);
  localparam int ColSumW    = 11;
  localparam int SumW       = 13;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;

  localparam logic [LineWidthW-1:0] LineWidthMin   = LineWidthW'(Taps);
  localparam logic [LineWidthW-1:0] LineWidthMax   = LineWidthW'(MaxLineWidth);
  localparam logic [LineWidthW-1:0] LineWidthReset = LineWidthW'(640);
  localparam logic [WeightW-1:0]    WeightReset    = WeightW'(256);
  localparam logic [ColW-1:0]       BorderCol      = ColW'(Taps - 1);
  localparam logic [RowW-1:0]       BorderRow      = RowW'(Taps - 1);
  localparam logic [ColW-1:0]       CenterOffCol   = ColW'(Taps / 2);
  localparam logic [RowW-1:0]       CenterOffRow   = RowW'(Taps / 2);

  typedef enum logic [CfgIdxW-1:0] {
    RegLineWidth     = 3'd0,
    RegCorner        = 3'd1,
    RegOuterOffaxis  = 3'd2,
    RegOuterAxis     = 3'd3,
    RegInnerDiag     = 3'd4,
    RegInnerAxis     = 3'd5,
    RegCenter        = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0] pixel_word;
    logic            frame_start;
  } in_t;

  typedef struct packed {
    logic [SumW-1:0] blurred_sum;
    logic [ColW-1:0] center_column;
    logic [RowW-1:0] center_row;
  } out_t;

  typedef logic [Taps-1:0][RedW-1:0]    tap_col_t;
  typedef logic [Taps-1:0][WeightW-1:0] weight_col_t;
  typedef logic [Slots-1:0][RedW-1:0]   slot_data_t;

  typedef struct packed {
    logic shift;
    logic term_en;
    logic sum_en;
  } cell_ctrl_t;

  // Weight class of a window place, by its row and column distance from the center.
  function automatic logic [ClassW-1:0] weight_class(input int dy, input int dx);
    int a;
    int b;
    int hi;
    int lo;
    logic [ClassW-1:0] cls;
    a  = (dy > Taps / 2) ? dy - Taps / 2 : Taps / 2 - dy;
    b  = (dx > Taps / 2) ? dx - Taps / 2 : Taps / 2 - dx;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    if (hi == 2 && lo == 2) cls = ClassW'(0);
    else if (hi == 2 && lo == 1) cls = ClassW'(1);
    else if (hi == 2) cls = ClassW'(2);
    else if (hi == 1 && lo == 1) cls = ClassW'(3);
    else if (hi == 1) cls = ClassW'(4);
    else cls = ClassW'(5);
    return cls;
  endfunction

endpackage

// ===== rtl/rcb_line_store.sv =====
// Four banked line stores holding the red bytes of the previous rows.
module rcb_line_store (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [rcb_pkg::ColW-1:0]            addr_i,
  input  logic [rcb_pkg::SlotW-1:0]           wr_slot_i,
  input  logic [rcb_pkg::RedW-1:0]            wr_data_i,
  output rcb_pkg::slot_data_t                 rd_data_o
);

  for (genvar s = 0; s < rcb_pkg::Slots; s++) begin : g_bank
    logic [rcb_pkg::RedW-1:0] line_mem [rcb_pkg::MaxLineWidth];
    logic [rcb_pkg::RedW-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (wr_slot_i == rcb_pkg::SlotW'(s)) begin
          line_mem[addr_i] <= wr_data_i;
        end
        rd_q <= line_mem[addr_i];
      end
    end

    assign rd_data_o[s] = rd_q;
  end

endmodule

// ===== rtl/rcb_cell.sv =====
// One window column: five taps, their clamped weighted terms and the column sum.
module rcb_cell (
  input  logic                          clk_i,
  input  rcb_pkg::cell_ctrl_t           ctrl_i,
  input  rcb_pkg::tap_col_t             col_i,
  input  rcb_pkg::weight_col_t          weight_i,
  output rcb_pkg::tap_col_t             col_o,
  output logic [rcb_pkg::ColSumW-1:0]   colsum_o
);

  rcb_pkg::tap_col_t                    taps_q;
  rcb_pkg::tap_col_t                    term_q;
  rcb_pkg::tap_col_t                    term_d;
  logic [rcb_pkg::ColSumW-1:0]          colsum_q;
  logic [rcb_pkg::ColSumW-1:0]          colsum_d;
  logic [rcb_pkg::Taps-1:0][rcb_pkg::ProdW-1:0] prod;

  always_comb begin
    for (int t = 0; t < rcb_pkg::Taps; t++) begin
      prod[t] = rcb_pkg::ProdW'(taps_q[t]) * rcb_pkg::ProdW'(weight_i[t]);
      if (prod[t][rcb_pkg::ProdW-1:rcb_pkg::FracW + rcb_pkg::RedW] != '0) begin
        term_d[t] = '1;
      end else begin
        term_d[t] = prod[t][rcb_pkg::FracW + rcb_pkg::RedW - 1:rcb_pkg::FracW];
      end
    end
  end

  always_comb begin
    colsum_d = '0;
    for (int t = 0; t < rcb_pkg::Taps; t++) begin
      colsum_d = colsum_d + rcb_pkg::ColSumW'(term_q[t]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      taps_q <= col_i;
    end
    if (ctrl_i.term_en) begin
      term_q <= term_d;
    end
    if (ctrl_i.sum_en) begin
      colsum_q <= colsum_d;
    end
  end

  assign col_o    = taps_q;
  assign colsum_o = colsum_q;

endmodule

// ===== rtl/red_channel_blur_5x5_unit.sv =====
// Top level of the streaming 5x5 weighted blur of the red channel.
//
// Pixels enter on the input channel in raster order, one transfer per pixel,
// with frame_start marking column 0 of row 0. Bits 23:16 of pixel_word are
// the red byte. A result leaves on the output channel only for pixels whose
// 5x5 window lies wholly inside the image; border pixels give none.
// From input transfer to result valid a pixel passes the registered stages
// line store read, window shift, weighted terms, column sums and final sum.
// One pixel is taken every cycle while in_stall_o is low, a rate set by the
// four line store banks: all read the pixel's column while its row's bank writes.
// When the receiver stalls, results wait in the pipeline registers, which
// keep taking pixels until every stage holds one; then in_stall_o
// rises. Configuration writes are taken at any cycle with cfg_we_i high,
// to be issued only while the block is idle. Reset clears the position,
// the pipeline valids, sets line_width to 640 and every weight to 1.0.
// The line stores are not cleared; rows are used only after being written.
module red_channel_blur_5x5_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rcb_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rcb_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rcb_pkg::out_t                 out_data_o
);

  logic [rcb_pkg::LineWidthW-1:0] line_width_q;
  logic [rcb_pkg::WeightW-1:0]    weight_q [rcb_pkg::Classes];

  logic [rcb_pkg::LineWidthW-1:0] width;
  logic [rcb_pkg::ColW-1:0]       col_q, col_d, cur_col;
  logic [rcb_pkg::RowW-1:0]       row_q, row_d, cur_row;
  logic                           in_accept;

  logic                           a_v_q, b_v_q, c_v_q, d_v_q, o_v_q;
  logic                           ready_a, ready_b, ready_c, ready_d, ready_o;
  logic                           a_res_q;
  logic [rcb_pkg::SlotW-1:0]      a_slot_q;
  logic [rcb_pkg::RedW-1:0]       a_red_q;
  logic [rcb_pkg::ColW-1:0]       a_col_q, b_col_q, c_col_q, d_col_q;
  logic [rcb_pkg::RowW-1:0]       a_row_q, b_row_q, c_row_q, d_row_q;
  rcb_pkg::out_t                  out_q;

  rcb_pkg::slot_data_t            rd_data;
  rcb_pkg::tap_col_t              new_col;
  rcb_pkg::cell_ctrl_t            cell_ctrl;
  rcb_pkg::tap_col_t              cell_col [rcb_pkg::Taps];
  rcb_pkg::weight_col_t           cell_weight [rcb_pkg::Taps];
  logic [rcb_pkg::ColSumW-1:0]    cell_sum [rcb_pkg::Taps];
  logic [rcb_pkg::SumW-1:0]       total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= rcb_pkg::LineWidthReset;
      for (int k = 0; k < rcb_pkg::Classes; k++) begin
        weight_q[k] <= rcb_pkg::WeightReset;
      end
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rcb_pkg::RegLineWidth:    line_width_q <= cfg_wdata_i[rcb_pkg::LineWidthW-1:0];
        rcb_pkg::RegCorner:       weight_q[0] <= cfg_wdata_i;
        rcb_pkg::RegOuterOffaxis: weight_q[1] <= cfg_wdata_i;
        rcb_pkg::RegOuterAxis:    weight_q[2] <= cfg_wdata_i;
        rcb_pkg::RegInnerDiag:    weight_q[3] <= cfg_wdata_i;
        rcb_pkg::RegInnerAxis:    weight_q[4] <= cfg_wdata_i;
        rcb_pkg::RegCenter:       weight_q[5] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the width, resolve the position of this pixel and of the next one.
  always_comb begin
    if (line_width_q < rcb_pkg::LineWidthMin) begin
      width = rcb_pkg::LineWidthMin;
    end else if (line_width_q > rcb_pkg::LineWidthMax) begin
      width = rcb_pkg::LineWidthMax;
    end else begin
      width = line_width_q;
    end
    if (in_data_i.frame_start) begin
      cur_col = '0;
      cur_row = '0;
    end else if (rcb_pkg::LineWidthW'(col_q) >= width) begin
      cur_col = '0;
      cur_row = row_q + 1'b1;
    end else begin
      cur_col = col_q;
      cur_row = row_q;
    end
    if (rcb_pkg::LineWidthW'(cur_col) + 1'b1 >= width) begin
      col_d = '0;
      row_d = cur_row + 1'b1;
    end else begin
      col_d = cur_col + 1'b1;
      row_d = cur_row;
    end
  end

  assign ready_o   = !o_v_q || !out_stall_i;
  assign ready_d   = !d_v_q || ready_o;
  assign ready_c   = !c_v_q || ready_d;
  assign ready_b   = !b_v_q || ready_c;
  assign ready_a   = !a_v_q || ready_b;
  assign in_stall_o = !ready_a;
  assign in_accept = in_valid_i && ready_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (in_accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (ready_a) a_v_q <= in_valid_i;
      if (ready_b) b_v_q <= a_v_q && a_res_q;
      if (ready_c) c_v_q <= b_v_q;
      if (ready_d) d_v_q <= c_v_q;
      if (ready_o) o_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_res_q  <= (cur_col >= rcb_pkg::BorderCol) && (cur_row >= rcb_pkg::BorderRow);
      a_slot_q <= cur_row[rcb_pkg::SlotW-1:0];
      a_red_q  <= in_data_i.pixel_word[23:16];
      a_col_q  <= cur_col - rcb_pkg::CenterOffCol;
      a_row_q  <= cur_row - rcb_pkg::CenterOffRow;
    end
    if (cell_ctrl.shift) begin
      b_col_q <= a_col_q;
      b_row_q <= a_row_q;
    end
    if (cell_ctrl.term_en) begin
      c_col_q <= b_col_q;
      c_row_q <= b_row_q;
    end
    if (cell_ctrl.sum_en) begin
      d_col_q <= c_col_q;
      d_row_q <= c_row_q;
    end
    if (d_v_q && ready_o) begin
      out_q.blurred_sum   <= total;
      out_q.center_column <= d_col_q;
      out_q.center_row    <= d_row_q;
    end
  end

  rcb_line_store u_line_store (
    .clk_i     (clk_i),
    .en_i      (in_accept),
    .addr_i    (cur_col),
    .wr_slot_i (cur_row[rcb_pkg::SlotW-1:0]),
    .wr_data_i (in_data_i.pixel_word[23:16]),
    .rd_data_o (rd_data)
  );

  // Order the new column oldest row first; the current pixel goes at the bottom.
  always_comb begin
    for (int dy = 0; dy < rcb_pkg::Slots; dy++) begin
      new_col[dy] = rd_data[a_slot_q + rcb_pkg::SlotW'(dy)];
    end
    new_col[rcb_pkg::Taps-1] = a_red_q;
  end

  assign cell_ctrl.shift   = a_v_q && ready_b;
  assign cell_ctrl.term_en = b_v_q && ready_c;
  assign cell_ctrl.sum_en  = c_v_q && ready_d;

  always_comb begin
    for (int dx = 0; dx < rcb_pkg::Taps; dx++) begin
      for (int dy = 0; dy < rcb_pkg::Taps; dy++) begin
        cell_weight[dx][dy] = weight_q[rcb_pkg::weight_class(dy, dx)];
      end
    end
  end

  for (genvar dx = 0; dx < rcb_pkg::Taps; dx++) begin : g_cell
    rcb_pkg::tap_col_t feed;
    if (dx == rcb_pkg::Taps - 1) begin : g_edge
      assign feed = new_col;
    end else begin : g_inner
      assign feed = cell_col[dx+1];
    end
    rcb_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .col_i    (feed),
      .weight_i (cell_weight[dx]),
      .col_o    (cell_col[dx]),
      .colsum_o (cell_sum[dx])
    );
  end

  always_comb begin
    total = '0;
    for (int dx = 0; dx < rcb_pkg::Taps; dx++) begin
      total = total + rcb_pkg::SumW'(cell_sum[dx]);
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== test/tb_top.sv =====
// Testbench for the streaming 5x5 red channel blur: directed table, random phases, self-checking.
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [rcb_pkg::PixW-1:0] word;
    bit                       sof;
    bit                       typed;
    rcb_pkg::out_t            want;
  } pix_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [rcb_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [rcb_pkg::CfgDataW-1:0] cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_stall_o;
  rcb_pkg::in_t                 in_data_i;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  rcb_pkg::out_t                out_data_o;

  logic [rcb_pkg::RedW-1:0]       line_rows [rcb_pkg::Slots][rcb_pkg::MaxLineWidth];
  logic [rcb_pkg::RedW-1:0]       window [rcb_pkg::Taps][rcb_pkg::Taps];
  int unsigned                    col_at;
  int unsigned                    row_at;
  logic [rcb_pkg::LineWidthW-1:0] width_cfg;
  logic [rcb_pkg::WeightW-1:0]    weight_cfg [8];
  logic [rcb_pkg::CfgDataW-1:0]   cfg_next [8];

  rcb_pkg::out_t       pending_sums [$];
  int unsigned         n_errors;
  int unsigned         n_pixels;
  int unsigned         n_checked;
  bit                  calm;

  pix_row_t seed_rows [25] = '{
    '{32'h00FF0000, 1'b1, 1'b0, '0}, '{32'hFFFFFFFF, 1'b0, 1'b0, '0},
    '{32'hAAFF5555, 1'b0, 1'b0, '0}, '{32'h55FFAAAA, 1'b0, 1'b0, '0},
    '{32'h00FF0000, 1'b0, 1'b0, '0}, '{32'hFFFF0000, 1'b0, 1'b0, '0},
    '{32'h00FFFFFF, 1'b0, 1'b0, '0}, '{32'h80FF0001, 1'b0, 1'b0, '0},
    '{32'h01FF8000, 1'b0, 1'b0, '0}, '{32'h00FF0000, 1'b0, 1'b0, '0},
    '{32'hFFFFFFFF, 1'b0, 1'b0, '0}, '{32'h00FF0000, 1'b0, 1'b0, '0},
    '{32'h55FF5555, 1'b0, 1'b0, '0}, '{32'hAAFFAAAA, 1'b0, 1'b0, '0},
    '{32'h00FF0000, 1'b0, 1'b0, '0}, '{32'hFFFF00FF, 1'b0, 1'b0, '0},
    '{32'h00FFFF00, 1'b0, 1'b0, '0}, '{32'h7FFF7FFF, 1'b0, 1'b0, '0},
    '{32'h00FF0000, 1'b0, 1'b0, '0}, '{32'hFEFFFFFE, 1'b0, 1'b0, '0},
    '{32'h00FF0000, 1'b0, 1'b0, '0}, '{32'hFFFFFFFF, 1'b0, 1'b0, '0},
    '{32'h12FF3456, 1'b0, 1'b0, '0}, '{32'h00FF0000, 1'b0, 1'b0, '0},
    '{32'hFFFFFFFF, 1'b0, 1'b1, {13'd6375, 11'd2, 12'd2}}
  };

  red_channel_blur_5x5_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb_top: errors");
    $finish;
  end

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= 20) begin
      $display("tb_top: mismatch at %0t: %s", $time, what);
    end
  endtask

  // Advance the blur state by one pixel; return 1 with the sum when the window is inside.
  function automatic bit step_blur(input rcb_pkg::in_t px, output rcb_pkg::out_t res);
    int unsigned       w;
    int unsigned       c;
    int unsigned       r;
    int unsigned       acc;
    int unsigned       term;
    int                da;
    int                db;
    int                hi;
    int                lo;
    rcb_pkg::cfg_reg_e cls;
    w = width_cfg;
    if (w < rcb_pkg::Taps) w = rcb_pkg::Taps;
    if (w > rcb_pkg::MaxLineWidth) w = rcb_pkg::MaxLineWidth;
    if (px.frame_start) begin
      col_at = 0;
      row_at = 0;
    end else if (col_at >= w) begin
      col_at = 0;
      row_at = (row_at + 1) % rcb_pkg::MaxRows;
    end
    c = col_at;
    r = row_at;
    for (int dy = 0; dy < rcb_pkg::Taps; dy++) begin
      for (int dx = 0; dx < rcb_pkg::Taps - 1; dx++) begin
        window[dy][dx] = window[dy][dx + 1];
      end
    end
    for (int dy = 0; dy < rcb_pkg::Slots; dy++) begin
      window[dy][rcb_pkg::Taps - 1] = line_rows[(r + dy) % rcb_pkg::Slots][c];
    end
    window[rcb_pkg::Taps - 1][rcb_pkg::Taps - 1] = px.pixel_word[23:16];
    line_rows[r % rcb_pkg::Slots][c] = px.pixel_word[23:16];
    if (c + 1 >= w) begin
      col_at = 0;
      row_at = (r + 1) % rcb_pkg::MaxRows;
    end else begin
      col_at = c + 1;
    end
    res = '0;
    if (c < rcb_pkg::Taps - 1 || r < rcb_pkg::Taps - 1) return 1'b0;
    acc = 0;
    for (int dy = 0; dy < rcb_pkg::Taps; dy++) begin
      for (int dx = 0; dx < rcb_pkg::Taps; dx++) begin
        da = (dy > 2) ? dy - 2 : 2 - dy;
        db = (dx > 2) ? dx - 2 : 2 - dx;
        hi = (da > db) ? da : db;
        lo = (da > db) ? db : da;
        if (hi == 2) begin
          cls = (lo == 2) ? rcb_pkg::RegCorner :
                (lo == 1) ? rcb_pkg::RegOuterOffaxis : rcb_pkg::RegOuterAxis;
        end else if (hi == 1) begin
          cls = (lo == 1) ? rcb_pkg::RegInnerDiag : rcb_pkg::RegInnerAxis;
        end else begin
          cls = rcb_pkg::RegCenter;
        end
        term = (int'(window[dy][dx]) * int'(weight_cfg[cls])) >> rcb_pkg::FracW;
        if (term > 255) term = 255;
        acc += term;
      end
    end
    res.blurred_sum   = rcb_pkg::SumW'(acc);
    res.center_column = rcb_pkg::ColW'(c - 2);
    res.center_row    = rcb_pkg::RowW'(r - 2);
    return 1'b1;
  endfunction

  function automatic logic [rcb_pkg::WeightW-1:0] pick_weight();
    logic [rcb_pkg::WeightW-1:0] v;
    case ($urandom_range(4))
      0: v = '0;
      1: v = '1;
      2: v = rcb_pkg::WeightReset;
      3: v = rcb_pkg::WeightW'($urandom_range(511));
      default: v = rcb_pkg::WeightW'($urandom);
    endcase
    return v;
  endfunction

  function automatic rcb_pkg::in_t rand_pixel(input bit sof);
    rcb_pkg::in_t p;
    p.pixel_word = $urandom;
    case ($urandom_range(7))
      0: p.pixel_word[23:16] = 8'hFF;
      1: p.pixel_word[23:16] = 8'h00;
      default: ;
    endcase
    p.frame_start = sof;
    return p;
  endfunction

  task automatic program_regs(input rcb_pkg::cfg_reg_e first, input rcb_pkg::cfg_reg_e last);
    for (int i = int'(first); i <= int'(last); i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= rcb_pkg::CfgIdxW'(i);
      cfg_wdata_i <= cfg_next[i];
      if (rcb_pkg::cfg_reg_e'(i) == rcb_pkg::RegLineWidth) begin
        width_cfg = cfg_next[i][rcb_pkg::LineWidthW-1:0];
      end else begin
        weight_cfg[i] = cfg_next[i];
      end
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_pixel(input rcb_pkg::in_t px, input bit typed, input rcb_pkg::out_t want);
    rcb_pkg::out_t got;
    bit            has;
    if (!calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    n_pixels++;
    has = step_blur(px, got);
    if (typed) pending_sums.push_back(want);
    else if (has) pending_sums.push_back(got);
  endtask

  task automatic run_stream(input int n, input bit fresh, input bit noise);
    bit sof;
    for (int j = 0; j < n; j++) begin
      sof = (fresh && j == 0) || (noise && $urandom_range(399) == 0);
      push_pixel(rand_pixel(sof), 1'b0, '0);
    end
  endtask

  // Hold the sender until every pending sum is out, then let the pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic roll_weights(input int ph);
    for (int k = int'(rcb_pkg::RegCorner); k <= int'(rcb_pkg::RegCenter); k++) begin
      case (ph)
        1: cfg_next[k] = '1;
        2: cfg_next[k] = '0;
        4: cfg_next[k] = rcb_pkg::WeightReset;
        default: cfg_next[k] = pick_weight();
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 15);
  end

  always @(posedge clk_i) begin
    rcb_pkg::out_t want;
    if (rst_ni && $isunknown(out_valid_o)) begin
      report_mismatch("out_valid_o unknown");
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("result with no pending sum");
      end else begin
        want = pending_sums.pop_front();
        n_checked++;
        if (out_data_o.blurred_sum !== want.blurred_sum) begin
          report_mismatch($sformatf("blurred_sum %0d, want %0d",
                                    out_data_o.blurred_sum, want.blurred_sum));
        end
        if (out_data_o.center_column !== want.center_column) begin
          report_mismatch($sformatf("center_column %0d, want %0d",
                                    out_data_o.center_column, want.center_column));
        end
        if (out_data_o.center_row !== want.center_row) begin
          report_mismatch($sformatf("center_row %0d, want %0d",
                                    out_data_o.center_row, want.center_row));
        end
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    calm        = 1'b0;
    n_errors    = 0;
    n_pixels    = 0;
    n_checked   = 0;
    col_at      = 0;
    row_at      = 0;
    width_cfg   = rcb_pkg::LineWidthReset;
    foreach (weight_cfg[k]) weight_cfg[k] = rcb_pkg::WeightReset;
    foreach (window[a, b]) window[a][b] = '0;
    foreach (line_rows[a, b]) line_rows[a][b] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Narrow width below range with upper bits set; weights stay at reset.
    cfg_next[rcb_pkg::RegLineWidth] = 16'hF003;
    program_regs(rcb_pkg::RegLineWidth, rcb_pkg::RegLineWidth);
    foreach (seed_rows[i]) begin
      push_pixel('{pixel_word: seed_rows[i].word, frame_start: seed_rows[i].sof},
                 seed_rows[i].typed, seed_rows[i].want);
    end
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: cfg_next[rcb_pkg::RegLineWidth] = 16'd0;
        5: cfg_next[rcb_pkg::RegLineWidth] = 16'hFFFF;
        default: cfg_next[rcb_pkg::RegLineWidth] = rcb_pkg::CfgDataW'($urandom_range(5, 24));
      endcase
      roll_weights(ph);
      program_regs(rcb_pkg::RegLineWidth, rcb_pkg::RegCenter);
      calm = (ph == 3);
      if (ph == 5) run_stream(200, 1'b1, 1'b0);
      else run_stream($urandom_range(130, 220), 1'b1, 1'b1);
      drain();
    end
    calm = 1'b0;

    // Shrink the width while the column count sits past the new width.
    cfg_next[rcb_pkg::RegLineWidth] = 16'd20;
    roll_weights(9);
    program_regs(rcb_pkg::RegLineWidth, rcb_pkg::RegCenter);
    run_stream(20 * 6 + 13, 1'b1, 1'b0);
    drain();
    cfg_next[rcb_pkg::RegLineWidth] = 16'd8;
    program_regs(rcb_pkg::RegLineWidth, rcb_pkg::RegLineWidth);
    run_stream(150, 1'b0, 1'b0);
    drain();

    $display("tb_top: %0d pixel transfers, %0d blurred sums checked", n_pixels, n_checked);
    $display("tb_top: width clamps, weight extremes, mid-line shrink, restarts, stalls");
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rcb_pkg.sv
rtl/rcb_line_store.sv
rtl/rcb_cell.sv
rtl/red_channel_blur_5x5_unit.sv
test/tb_top.sv
